// ===== hw/rtl/vector_align_rotation_matrix_unit_defines.svh =====
// Assertion macros shared by the RTL of the rotation matrix unit.
`ifndef VECTOR_ALIGN_ROTATION_MATRIX_UNIT_DEFINES_SVH
`define VECTOR_ALIGN_ROTATION_MATRIX_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define VARM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define VARM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define VARM_ASSERT(lbl, prop)
`define VARM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/varm_pkg.sv =====
`default_nettype none
package varm_pkg;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int LIM_WIDTH  = 15;
  localparam logic [LIM_WIDTH-1:0] LIM_RESET = LIM_WIDTH'(16);
  // Wide working width for sums before saturation.
  localparam int SW  = 2 * DATA_WIDTH + 4;
  // Rounded product width.
  localparam int RW  = 2 * DATA_WIDTH - FRAC_BITS + 1;
  // Quotient magnitude width and divisor width.
  localparam int QW  = 2 * DATA_WIDTH - 1;
  localparam int DVW = DATA_WIDTH + 1;
  localparam int NLANE = 6;
  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_ONE =
    (FRAC_BITS >= DATA_WIDTH - 1) ? SAT_MAX : DATA_WIDTH'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] ONE_W  = SW'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] HALF_W = SW'(64'd1 << (FRAC_BITS - 1));

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic [DVW-1:0] rem;
    logic [QW-1:0]  nq;
    logic           neg;
  } lane_t;

  typedef struct packed {
    logic           valid;
    logic           degen;
    logic [DVW-1:0] d;
    data_t          c;
    data_t          vx;
    data_t          vy;
    data_t          vz;
    lane_t [NLANE-1:0] lane;
  } div_stage_t;

  function automatic data_t sat(input logic signed [SW-1:0] x);
    if (x > SW'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (x < SW'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return x[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [RW-1:0] rprod(input data_t a, input data_t b);
    logic signed [SW-1:0] p;
    p = SW'(a) * SW'(b) + HALF_W;
    p = p >>> FRAC_BITS;
    return p[RW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/vector_align_rotation_matrix_unit.sv =====
// Rotation matrix that turns a reference unit vector onto a target unit vector.
// Input: a transfer happens at a rising edge with start high and busy low; busy
// is always low, so a vector pair can enter in every cycle. Six signed Q2.14
// components per pair: in_dir_* (target) and in_ref_* (reference).
// Output: out_valid strobes for one cycle with the nine saturated Q2.14 matrix
// entries out_m00..out_m22 and out_degenerate. The receiver cannot stall.
// The pipeline registers, in order: the cross/dot products, their sums, the six
// v products and their magnitudes, then one quotient bit per stage through QW
// restoring divider stages shared by the six quotients, then the output register.
// Throughput is one pair a cycle.
// Configuration: cfg_data sets degenerate_limit on a cfg_valid/cfg_ready
// transfer (cfg_ready is always high); write it only while the pipeline is empty.
// When 1+c is at or below the limit, out_degenerate is set and the identity is
// returned. Reset (rst_n low, synchronous) empties the pipeline and sets the
// limit to 16.
`default_nettype none
`include "vector_align_rotation_matrix_unit_defines.svh"
module vector_align_rotation_matrix_unit
  import varm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [DATA_WIDTH-1:0] in_dir_x,
  input  wire logic [DATA_WIDTH-1:0] in_dir_y,
  input  wire logic [DATA_WIDTH-1:0] in_dir_z,
  input  wire logic [DATA_WIDTH-1:0] in_ref_x,
  input  wire logic [DATA_WIDTH-1:0] in_ref_y,
  input  wire logic [DATA_WIDTH-1:0] in_ref_z,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [LIM_WIDTH-1:0] cfg_data,
  output logic                      out_valid,
  output logic [DATA_WIDTH-1:0]     out_m00,
  output logic [DATA_WIDTH-1:0]     out_m01,
  output logic [DATA_WIDTH-1:0]     out_m02,
  output logic [DATA_WIDTH-1:0]     out_m10,
  output logic [DATA_WIDTH-1:0]     out_m11,
  output logic [DATA_WIDTH-1:0]     out_m12,
  output logic [DATA_WIDTH-1:0]     out_m20,
  output logic [DATA_WIDTH-1:0]     out_m21,
  output logic [DATA_WIDTH-1:0]     out_m22,
  output logic                      out_degenerate
);
  localparam int LXX = 0;
  localparam int LYY = 1;
  localparam int LZZ = 2;
  localparam int LXY = 3;
  localparam int LXZ = 4;
  localparam int LYZ = 5;

  logic [LIM_WIDTH-1:0] limit_r;

  // Stage 1: rounded scalar products.
  logic s1_valid_r;
  logic signed [RW-1:0] p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;
  logic signed [RW-1:0] p_xx_r, p_yy_r, p_zz_r;

  // Stage 2: cross and dot product.
  logic s2_valid_r, s2_degen_r;
  data_t s2_vx_r, s2_vy_r, s2_vz_r, s2_c_r;
  logic signed [SW-1:0] s2_opc_r;
  logic signed [SW-1:0] opc_nxt, lim_w;

  // Stage 3: products of v components.
  logic s3_valid_r, s3_degen_r;
  data_t s3_vx_r, s3_vy_r, s3_vz_r, s3_c_r;
  logic [DVW-1:0] s3_d_r;
  logic signed [2*DATA_WIDTH-1:0] s3_p_r [NLANE];

  div_stage_t div_r   [QW+1];
  div_stage_t div_nxt [QW+1];
  div_stage_t load_nxt;

  data_t m_nxt [9];
  logic signed [SW-1:0] q_w [NLANE];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p_yz_r <= rprod(data_t'(in_ref_y), data_t'(in_dir_z));
    p_zy_r <= rprod(data_t'(in_ref_z), data_t'(in_dir_y));
    p_zx_r <= rprod(data_t'(in_ref_z), data_t'(in_dir_x));
    p_xz_r <= rprod(data_t'(in_ref_x), data_t'(in_dir_z));
    p_xy_r <= rprod(data_t'(in_ref_x), data_t'(in_dir_y));
    p_yx_r <= rprod(data_t'(in_ref_y), data_t'(in_dir_x));
    p_xx_r <= rprod(data_t'(in_ref_x), data_t'(in_dir_x));
    p_yy_r <= rprod(data_t'(in_ref_y), data_t'(in_dir_y));
    p_zz_r <= rprod(data_t'(in_ref_z), data_t'(in_dir_z));
  end

  data_t c_nxt;
  assign c_nxt   = sat(SW'(p_xx_r) + SW'(p_yy_r) + SW'(p_zz_r));
  assign opc_nxt = ONE_W + SW'(c_nxt);
  assign lim_w   = SW'(limit_r);

  always_ff @(posedge clk) begin
    s2_vx_r    <= sat(SW'(p_yz_r) - SW'(p_zy_r));
    s2_vy_r    <= sat(SW'(p_zx_r) - SW'(p_xz_r));
    s2_vz_r    <= sat(SW'(p_xy_r) - SW'(p_yx_r));
    s2_c_r     <= c_nxt;
    s2_opc_r   <= opc_nxt;
    s2_degen_r <= opc_nxt <= lim_w;
  end

  always_ff @(posedge clk) begin
    s3_degen_r <= s2_degen_r;
    s3_vx_r    <= s2_vx_r;
    s3_vy_r    <= s2_vy_r;
    s3_vz_r    <= s2_vz_r;
    s3_c_r     <= s2_c_r;
    // A degenerate item divides by one; its quotients are discarded.
    s3_d_r     <= s2_degen_r ? DVW'(1) : s2_opc_r[DVW-1:0];
    s3_p_r[LXX] <= s2_vx_r * s2_vx_r;
    s3_p_r[LYY] <= s2_vy_r * s2_vy_r;
    s3_p_r[LZZ] <= s2_vz_r * s2_vz_r;
    s3_p_r[LXY] <= s2_vx_r * s2_vy_r;
    s3_p_r[LXZ] <= s2_vx_r * s2_vz_r;
    s3_p_r[LYZ] <= s2_vy_r * s2_vz_r;
  end

  // Divider entry: magnitude and sign of each dividend.
  always_comb begin
    logic signed [2*DATA_WIDTH-1:0] mag;
    load_nxt.valid = s3_valid_r;
    load_nxt.degen = s3_degen_r;
    load_nxt.d     = s3_d_r;
    load_nxt.c     = s3_c_r;
    load_nxt.vx    = s3_vx_r;
    load_nxt.vy    = s3_vy_r;
    load_nxt.vz    = s3_vz_r;
    for (int l = 0; l < NLANE; l++) begin
      mag = s3_p_r[l][2*DATA_WIDTH-1] ? -s3_p_r[l] : s3_p_r[l];
      load_nxt.lane[l].rem = '0;
      load_nxt.lane[l].nq  = mag[QW-1:0];
      load_nxt.lane[l].neg = s3_p_r[l][2*DATA_WIDTH-1];
    end
  end

  // One restoring step per stage: the dividend leaves nq at the top while the
  // quotient bits come in at the bottom.
  always_comb begin
    logic [DVW:0] tr;
    div_nxt[0] = load_nxt;
    for (int k = 1; k <= QW; k++) begin
      div_nxt[k] = div_r[k-1];
      for (int l = 0; l < NLANE; l++) begin
        tr = {div_r[k-1].lane[l].rem, div_r[k-1].lane[l].nq[QW-1]};
        if (tr >= {1'b0, div_r[k-1].d}) begin
          div_nxt[k].lane[l].rem = DVW'(tr - {1'b0, div_r[k-1].d});
          div_nxt[k].lane[l].nq  = {div_r[k-1].lane[l].nq[QW-2:0], 1'b1};
        end else begin
          div_nxt[k].lane[l].rem = tr[DVW-1:0];
          div_nxt[k].lane[l].nq  = {div_r[k-1].lane[l].nq[QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) begin
        div_r[k].valid <= 1'b0;
      end
    end else begin
      for (int k = 0; k <= QW; k++) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] c_w, vx_w, vy_w, vz_w;
    for (int l = 0; l < NLANE; l++) begin
      q_w[l] = div_r[QW].lane[l].neg ? -SW'(div_r[QW].lane[l].nq)
                                     : SW'(div_r[QW].lane[l].nq);
    end
    c_w  = SW'(div_r[QW].c);
    vx_w = SW'(div_r[QW].vx);
    vy_w = SW'(div_r[QW].vy);
    vz_w = SW'(div_r[QW].vz);
    if (div_r[QW].degen) begin
      for (int i = 0; i < 9; i++) begin
        m_nxt[i] = (i % 4 == 0) ? SAT_ONE : '0;
      end
    end else begin
      m_nxt[0] = sat(q_w[LXX] + c_w);
      m_nxt[1] = sat(q_w[LXY] - vz_w);
      m_nxt[2] = sat(q_w[LXZ] + vy_w);
      m_nxt[3] = sat(q_w[LXY] + vz_w);
      m_nxt[4] = sat(q_w[LYY] + c_w);
      m_nxt[5] = sat(q_w[LYZ] - vx_w);
      m_nxt[6] = sat(q_w[LXZ] - vy_w);
      m_nxt[7] = sat(q_w[LYZ] + vx_w);
      m_nxt[8] = sat(q_w[LZZ] + c_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= div_r[QW].valid;
    end
    out_m00        <= m_nxt[0];
    out_m01        <= m_nxt[1];
    out_m02        <= m_nxt[2];
    out_m10        <= m_nxt[3];
    out_m11        <= m_nxt[4];
    out_m12        <= m_nxt[5];
    out_m20        <= m_nxt[6];
    out_m21        <= m_nxt[7];
    out_m22        <= m_nxt[8];
    out_degenerate <= div_r[QW].degen;
  end

  `VARM_ASSERT(a_degen_identity, out_valid && out_degenerate |-> out_m01 == '0 && out_m10 == '0 && out_m12 == '0 && out_m11 == SAT_ONE)
  `VARM_ASSERT(a_divisor_positive, s2_valid_r && !s2_degen_r |-> s2_opc_r > SW'(0))
  `VARM_ASSERT(a_valid_follows, out_valid |-> $past(div_r[QW].valid))
  `VARM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !s1_valid_r)
endmodule
`default_nettype wire
